// ----- hw/rtl/coo_sparse_matvec_core_macros.svh -----
// Assertion macros for the sparse matrix-vector core RTL.
`ifndef COO_SPARSE_MATVEC_CORE_MACROS_SVH
`define COO_SPARSE_MATVEC_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside of reset.
`define SMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside of reset.
`define SMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SMV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SMV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/coo_smv_pkg.sv -----
// Shared types and constants of the sparse matrix-vector core.
`timescale 1ns / 1ps
package coo_smv_pkg;

  // Fixed field widths.
  localparam int IDX_W  = 12;
  localparam int MODE_W = 2;
  localparam int ACC_W  = 48;

  // Default sizes for the top-level parameters.
  localparam int DEF_ROW_DEPTH    = 4096;
  localparam int DEF_COLUMN_DEPTH = 4096;
  localparam int DEF_VALUE_BITS   = 16;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_ACC  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NOP  = 2'd3
  } smv_mode_t;

  // Control tag that travels with an item down the accumulate pipeline.
  typedef struct packed {
    logic valid;
    logic rd;
    logic row_ok;
  } smv_op_t;

endpackage

// ----- hw/rtl/coo_sparse_matvec_core.sv -----
// Top level of the coordinate-form sparse matrix times dense vector core.
`timescale 1ns / 1ps
`include "coo_sparse_matvec_core_macros.svh"
// The core keeps the dense vector and the row accumulators in two on-chip RAMs
// and takes one item per cycle once running, unless input is held off: a vector
// load (mode 0) writes the vector RAM at once, an accumulate (mode 1) or row read
// (mode 2) goes through a read, multiply, add-and-write-back pipeline on the
// accumulator RAM, with the last write forwarded so back-to-back updates of one
// row stay exact. A row read's result passes stage one and stage two into an
// output register that raises out_valid, and input is held off only when a
// second result finds that register still full. After reset the core zeroes the
// accumulator RAM, one row per cycle, and takes no input until it is done.
module coo_sparse_matvec_core #(
  parameter int ROW_DEPTH    = coo_smv_pkg::DEF_ROW_DEPTH,
  parameter int COLUMN_DEPTH = coo_smv_pkg::DEF_COLUMN_DEPTH,
  parameter int VALUE_BITS   = coo_smv_pkg::DEF_VALUE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [coo_smv_pkg::MODE_W-1:0]       in_mode,
  input  logic [coo_smv_pkg::IDX_W-1:0]        in_index,
  input  logic [coo_smv_pkg::IDX_W-1:0]        in_column,
  input  logic signed [VALUE_BITS-1:0]         in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [coo_smv_pkg::IDX_W-1:0]        out_row_index,
  output logic signed [coo_smv_pkg::ACC_W-1:0] out_row_sum,
  output logic                                 out_saturated
);
  import coo_smv_pkg::*;

  localparam int RA = $clog2(ROW_DEPTH);
  localparam int CA = $clog2(COLUMN_DEPTH);
  localparam logic [RA-1:0] LAST_ROW = RA'(ROW_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } smv_state_t;

  smv_state_t               state_r, state_nxt;
  logic [RA-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic                     clear_we;

  logic                     adv;
  logic                     in_accept;
  logic                     row_ok, col_ok, vec_idx_ok;
  logic                     issue_acc, issue_rd;

  logic                     vec_we, vec_re;
  logic signed [VALUE_BITS-1:0] vec_rdata;
  logic                     acc_re;
  logic [ACC_W:0]           acc_rdata;
  logic                     ram_we;
  logic [RA-1:0]            ram_waddr;
  logic [ACC_W:0]           ram_wdata;

  smv_op_t                  s1_op_r;
  logic [RA-1:0]            s1_addr_r;
  logic [IDX_W-1:0]         s1_index_r;
  logic signed [VALUE_BITS-1:0] s1_value_r;

  logic                     mac_we;
  logic [RA-1:0]            mac_waddr;
  logic [ACC_W:0]           mac_wdata;
  logic                     res_valid;
  logic [IDX_W-1:0]         res_index;
  logic signed [ACC_W-1:0]  res_sum;
  logic                     res_flag;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_load;
  logic [IDX_W-1:0]         out_row_index_r;
  logic signed [ACC_W-1:0]  out_row_sum_r;
  logic                     out_saturated_r;

  // Clearing pass over the accumulator RAM after reset.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    clear_we    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clear_we    = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // The pipeline stops only when a row result meets a full output register.
  assign adv       = !(res_valid && out_valid_r && !out_ready);
  assign in_ready  = (state_r == ST_RUN) && adv;
  assign in_accept = in_valid && in_ready;

  // Decode of the incoming transfer.
  assign row_ok     = int'(in_index) < ROW_DEPTH;
  assign col_ok     = int'(in_column) < COLUMN_DEPTH;
  assign vec_idx_ok = int'(in_index) < COLUMN_DEPTH;
  assign issue_acc  = (in_mode == MODE_ACC) && row_ok && col_ok;
  assign issue_rd   = (in_mode == MODE_READ);

  assign vec_we = in_accept && (in_mode == MODE_LOAD) && vec_idx_ok;
  assign vec_re = in_accept && issue_acc;
  assign acc_re = in_accept && (issue_acc || issue_rd);

  // Dense vector store.
  coo_smv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (COLUMN_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (CA'(in_index)),
    .wdata (in_value),
    .re    (vec_re),
    .raddr (CA'(in_column)),
    .rdata (vec_rdata)
  );

  // Accumulator store: sticky saturation flag over the 48-bit sum.
  assign ram_we    = clear_we || mac_we;
  assign ram_waddr = clear_we ? clr_cnt_r : mac_waddr;
  assign ram_wdata = clear_we ? '0 : mac_wdata;

  coo_smv_ram #(
    .WIDTH (ACC_W + 1),
    .DEPTH (ROW_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc_re),
    .raddr (RA'(in_index)),
    .rdata (acc_rdata)
  );

  // Stage one: the item waits here for its RAM read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_op_r <= '0;
    end else if (adv) begin
      s1_op_r.valid  <= acc_re;
      s1_op_r.rd     <= issue_rd;
      s1_op_r.row_ok <= row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r  <= RA'(in_index);
      s1_index_r <= in_index;
      s1_value_r <= in_value;
    end
  end

  coo_smv_mac #(
    .RA         (RA),
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_op     (s1_op_r),
    .s1_addr   (s1_addr_r),
    .s1_index  (s1_index_r),
    .s1_value  (s1_value_r),
    .vec_rdata (vec_rdata),
    .acc_rdata (acc_rdata),
    .acc_we    (mac_we),
    .acc_waddr (mac_waddr),
    .acc_wdata (mac_wdata),
    .res_valid (res_valid),
    .res_index (res_index),
    .res_sum   (res_sum),
    .res_flag  (res_flag)
  );

  // Output register for row results.
  assign out_load = res_valid && adv;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_index_r <= res_index;
      out_row_sum_r   <= res_sum;
      out_saturated_r <= res_flag;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_sum   = out_row_sum_r;
  assign out_saturated = out_saturated_r;

  // No transfer is taken while the accumulator RAM is being cleared.
  `SMV_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_accept)
  // The clearing pass and the pipeline never write the accumulator RAM together.
  `SMV_ASSERT_IMP(a_one_acc_writer, clk, rst_n, clear_we, !mac_we)
  // The pipeline writes only rows that exist.
  `SMV_ASSERT_IMP(a_wb_in_range, clk, rst_n, mac_we, int'(mac_waddr) < ROW_DEPTH)
  // A row result that cannot move to the output is held in the pipeline.
  `SMV_ASSERT_NEXT(a_result_held, clk, rst_n, res_valid && !adv, res_valid)
  // The clearing pass ends after the last row.
  `SMV_ASSERT_NEXT(a_clear_done, clk, rst_n, (state_r == ST_CLEAR) && (clr_cnt_r == LAST_ROW),
                   state_r == ST_RUN)

endmodule

// ----- hw/rtl/coo_smv_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module coo_smv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/coo_smv_mac.sv -----
// Multiply, forwarding and saturating accumulate stages of the sparse matrix-vector core.
`timescale 1ns / 1ps
module coo_smv_mac #(
  parameter int RA         = 12,
  parameter int VALUE_BITS = coo_smv_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  coo_smv_pkg::smv_op_t            s1_op,
  input  logic [RA-1:0]                   s1_addr,
  input  logic [coo_smv_pkg::IDX_W-1:0]   s1_index,
  input  logic signed [VALUE_BITS-1:0]    s1_value,
  input  logic signed [VALUE_BITS-1:0]    vec_rdata,
  input  logic [coo_smv_pkg::ACC_W:0]     acc_rdata,
  output logic                            acc_we,
  output logic [RA-1:0]                   acc_waddr,
  output logic [coo_smv_pkg::ACC_W:0]     acc_wdata,
  output logic                            res_valid,
  output logic [coo_smv_pkg::IDX_W-1:0]   res_index,
  output logic signed [coo_smv_pkg::ACC_W-1:0] res_sum,
  output logic                            res_flag
);
  import coo_smv_pkg::*;

  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  smv_op_t                   s2_op_r;
  logic [RA-1:0]             s2_addr_r;
  logic [IDX_W-1:0]          s2_index_r;
  logic [ACC_W:0]            s2_acc_r;
  logic signed [PROD_W-1:0]  s2_prod_r;

  logic                      wb_valid_r;
  logic [RA-1:0]             wb_addr_r;
  logic [ACC_W:0]            wb_data_r;

  logic [ACC_W:0]            acc_in;
  logic [ACC_W:0]            acc_cur;
  logic signed [ACC_W-1:0]   acc_val;
  logic                      flag_old;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc_new;
  logic                      sat;

  // The write that lands on the read edge is missed by the RAM; take it from the last write.
  assign acc_in = (wb_valid_r && (wb_addr_r == s1_addr)) ? wb_data_r : acc_rdata;

  // Stage two control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_op_r <= '0;
    end else if (adv) begin
      s2_op_r <= s1_op;
    end
  end

  // Stage two payload: the registered product and the forwarded accumulator.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_addr_r  <= s1_addr;
      s2_index_r <= s1_index;
      s2_acc_r   <= acc_in;
      s2_prod_r  <= s1_value * vec_rdata;
    end
  end

  // A write by the item just ahead is newer than what stage two captured.
  assign acc_cur  = (wb_valid_r && (wb_addr_r == s2_addr_r)) ? wb_data_r : s2_acc_r;
  assign acc_val  = acc_cur[ACC_W-1:0];
  assign flag_old = acc_cur[ACC_W];
  assign sum      = SUM_W'(acc_val) + SUM_W'(s2_prod_r);

  // Clamp the exact sum to the accumulator range.
  always_comb begin
    priority if (sum > SAT_HI) begin
      acc_new = SAT_HI[ACC_W-1:0];
      sat     = 1'b1;
    end else if (sum < SAT_LO) begin
      acc_new = SAT_LO[ACC_W-1:0];
      sat     = 1'b1;
    end else begin
      acc_new = sum[ACC_W-1:0];
      sat     = 1'b0;
    end
  end

  // Write back: a read clears the row, an accumulate stores the new sum and sticky flag.
  assign acc_we    = adv && s2_op_r.valid && s2_op_r.row_ok;
  assign acc_waddr = s2_addr_r;
  assign acc_wdata = s2_op_r.rd ? '0 : {flag_old | sat, acc_new};

  // Most recent write, kept for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (acc_we) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      wb_addr_r <= acc_waddr;
      wb_data_r <= acc_wdata;
    end
  end

  // Row read result; a row beyond the store returns zero.
  assign res_valid = s2_op_r.valid && s2_op_r.rd;
  assign res_index = s2_index_r;
  assign res_sum   = s2_op_r.row_ok ? acc_val : '0;
  assign res_flag  = s2_op_r.row_ok && flag_old;

endmodule

// ----- tb/tb_coo_sparse_matvec_core.sv -----
// Self-checking testbench for the coordinate-form sparse matrix-vector core.
`timescale 1ns / 1ps
module tb_coo_sparse_matvec_core;
  import coo_smv_pkg::*;

  localparam int VAL_W = DEF_VALUE_BITS;
  localparam int DEPTH = DEF_ROW_DEPTH;
  localparam int IDX_MAX = DEPTH - 1;
  localparam int VAL_MAX = (1 << (VAL_W - 1)) - 1;
  localparam int VAL_MIN = -VAL_MAX - 1;
  localparam longint SUM_MAX = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  // Length of each run of full-scale products into one row.
  localparam int LONG_RUN = 16;
  // Covers the accumulator clearing pass after reset with a wide margin.
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    smv_mode_t mode;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] column;
    logic signed [VAL_W-1:0] value;
  } smv_item_t;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic signed [ACC_W-1:0] sum;
    logic sat;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [IDX_W-1:0] in_index = '0;
  logic [IDX_W-1:0] in_column = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_row_index;
  logic signed [ACC_W-1:0] out_row_sum;
  logic out_saturated;

  // Items waiting to be driven and row sums waiting to come back.
  smv_item_t items_todo[$];
  row_result_t sums_due[$];
  smv_item_t next_item;
  smv_item_t seen_item;
  row_result_t due;

  // Predicted contents of the vector store and of the row accumulators.
  logic signed [VAL_W-1:0] vec_elem [DEPTH];
  longint row_acc [DEPTH];
  bit row_clamped [DEPTH];

  // Columns the stimulus has loaded so far; nonzeros only use these.
  bit col_loaded [DEPTH];
  int loaded_cols[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_queued = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_sat_reads = 0;
  int n_errors = 0;
  int quiet_cycles = 0;

  coo_sparse_matvec_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_index     (in_index),
    .in_column    (in_column),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row_index(out_row_index),
    .out_row_sum  (out_row_sum),
    .out_saturated(out_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted item to the predicted state; a row read yields a sum.
  function automatic void matvec_step(smv_item_t it);
    longint prod;
    longint acc;
    row_result_t res;
    case (it.mode)
      MODE_LOAD: vec_elem[it.index] = it.value;
      MODE_ACC: begin
        prod = longint'(it.value) * longint'(vec_elem[it.column]);
        acc = row_acc[it.index] + prod;
        if (acc > SUM_MAX) begin
          acc = SUM_MAX;
          row_clamped[it.index] = 1'b1;
        end else if (acc < SUM_MIN) begin
          acc = SUM_MIN;
          row_clamped[it.index] = 1'b1;
        end
        row_acc[it.index] = acc;
      end
      MODE_READ: begin
        res.row = it.index;
        res.sum = ACC_W'(row_acc[it.index]);
        res.sat = row_clamped[it.index];
        sums_due.push_back(res);
        row_acc[it.index] = 0;
        row_clamped[it.index] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(smv_mode_t m, int idx, int col, int val);
    smv_item_t it;
    it.mode = m;
    it.index = idx[IDX_W-1:0];
    it.column = col[IDX_W-1:0];
    it.value = val[VAL_W-1:0];
    items_todo.push_back(it);
    n_queued++;
    if (m == MODE_LOAD && !col_loaded[it.index]) begin
      col_loaded[it.index] = 1'b1;
      loaded_cols.push_back(it.index);
    end
  endfunction

  // Values lean toward the full-scale corners and the small ones.
  function automatic int rand_value();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return $urandom_range(1) ? 1 : -1;
      3: return 0;
      default: return int'($urandom_range((1 << VAL_W) - 1)) + VAL_MIN;
    endcase
  endfunction

  // One small matrix-vector product: load a few columns, scatter nonzeros
  // over a few rows, then read every row back.
  function automatic void queue_problem();
    int n_rows;
    int n_cols;
    int row_base;
    int col_base;
    int n_nz;
    n_rows = $urandom_range(1, 6);
    n_cols = $urandom_range(1, 6);
    row_base = $urandom_range(0, IDX_MAX - 5);
    col_base = $urandom_range(0, IDX_MAX - 5);
    n_nz = $urandom_range(1, 12);
    for (int c = 0; c < n_cols; c++)
      queue_item(MODE_LOAD, col_base + c, $urandom_range(IDX_MAX), rand_value());
    for (int k = 0; k < n_nz; k++)
      queue_item(MODE_ACC, row_base + $urandom_range(0, n_rows - 1),
                 col_base + $urandom_range(0, n_cols - 1), rand_value());
    for (int r = 0; r < n_rows; r++)
      queue_item(MODE_READ, row_base + r, $urandom_range(IDX_MAX), rand_value());
  endfunction

  // Stray items: unused mode, lone reads and loads, nonzeros nobody reads yet.
  function automatic void queue_noise();
    case ($urandom_range(3))
      0: queue_item(MODE_NOP, $urandom_range(IDX_MAX), $urandom_range(IDX_MAX), rand_value());
      1: queue_item(MODE_READ, $urandom_range(IDX_MAX), $urandom_range(IDX_MAX), rand_value());
      2: queue_item(MODE_LOAD, $urandom_range(IDX_MAX), $urandom_range(IDX_MAX), rand_value());
      default: queue_item(MODE_ACC, $urandom_range(IDX_MAX),
                          loaded_cols[$urandom_range(loaded_cols.size() - 1)], rand_value());
    endcase
  endfunction

  task automatic wait_drained();
    while (n_taken != n_queued || sums_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int n_items);
    int goal;
    @(negedge clk);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    goal = n_queued + n_items;
    while (n_queued < goal) begin
      if ($urandom_range(99) < 15) queue_noise();
      else queue_problem();
    end
    wait_drained();
  endtask

  // Input driver and result-side stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_ready) begin
        if (items_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = items_todo.pop_front();
          in_mode <= next_item.mode;
          in_index <= next_item.index;
          in_column <= next_item.column;
          in_value <= next_item.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen_item.mode = smv_mode_t'(in_mode);
        seen_item.index = in_index;
        seen_item.column = in_column;
        seen_item.value = in_value;
        matvec_step(seen_item);
        n_taken++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (sums_due.size() == 0) begin
          $error("unexpected result for row %0d", out_row_index);
          n_errors++;
        end else begin
          due = sums_due.pop_front();
          if (out_row_index !== due.row) begin
            $error("row_index: expected %0d, got %0d", due.row, out_row_index);
            n_errors++;
          end
          if (out_row_sum !== due.sum) begin
            $error("row_sum: expected %0d, got %0d", due.sum, out_row_sum);
            n_errors++;
          end
          if (out_saturated !== due.sat) begin
            $error("saturated: expected %0b, got %0b", due.sat, out_saturated);
            n_errors++;
          end
          if (due.sat) n_sat_reads++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
      $display("** coo_sparse_matvec_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes and the basic accumulate and read-back flow.
    queue_item(MODE_LOAD, 0, IDX_MAX, VAL_MAX);
    queue_item(MODE_LOAD, IDX_MAX, 0, VAL_MIN);
    queue_item(MODE_LOAD, 1, 0, -1);
    queue_item(MODE_ACC, 0, 0, VAL_MIN);
    queue_item(MODE_ACC, 0, IDX_MAX, VAL_MIN);
    queue_item(MODE_ACC, IDX_MAX, IDX_MAX, VAL_MAX);
    queue_item(MODE_ACC, IDX_MAX, 1, 1);
    queue_item(MODE_READ, 0, IDX_MAX, 0);
    queue_item(MODE_READ, IDX_MAX, 0, -1);
    // A row never touched, and one that was just cleared by a read.
    queue_item(MODE_READ, 5, 0, 0);
    queue_item(MODE_READ, 0, 0, 0);
    // The unused mode does nothing.
    queue_item(MODE_NOP, IDX_MAX, IDX_MAX, -1);
    queue_item(MODE_NOP, 0, 0, 0);
    // Back-to-back updates of one row with the read right behind them.
    queue_item(MODE_LOAD, 2, IDX_MAX, VAL_MAX);
    queue_item(MODE_ACC, 1, 2, VAL_MIN);
    queue_item(MODE_ACC, 1, 2, VAL_MIN);
    queue_item(MODE_ACC, 1, 2, VAL_MIN);
    queue_item(MODE_READ, 1, 0, 0);
    queue_item(MODE_ACC, 1, 2, 1);
    queue_item(MODE_READ, 1, 0, 0);
    // Reloading a column changes the next product at once.
    queue_item(MODE_LOAD, 2, 0, 3);
    queue_item(MODE_ACC, 3, 2, 7);
    queue_item(MODE_READ, 3, 0, 0);

    // Long runs of full-scale products into one row in each direction,
    // then reads that must clear the rows.
    queue_item(MODE_LOAD, 3, 0, VAL_MIN);
    repeat (LONG_RUN) queue_item(MODE_ACC, 7, 3, VAL_MIN);
    queue_item(MODE_ACC, 7, 3, VAL_MAX);
    queue_item(MODE_READ, 7, 0, 0);
    repeat (LONG_RUN) queue_item(MODE_ACC, 8, 3, VAL_MAX);
    queue_item(MODE_ACC, 8, 3, VAL_MIN);
    queue_item(MODE_READ, 8, 0, 0);
    queue_item(MODE_READ, 7, 0, 0);
    wait_drained();

    run_phase(0, 0, 310);
    run_phase(78, 0, 310);
    run_phase(0, 78, 310);
    run_phase(20, 20, 310);

    repeat (10) @(posedge clk);
    $display("Covered %0d input transfers and %0d row reads, %0d of them saturated,",
             n_taken, n_results, n_sat_reads);
    $display("with no idling, sender idle 78%%, receiver stalled 78%%, and both at 20%%.");
    if (n_errors == 0) begin
      $display("** coo_sparse_matvec_core: PASSED **");
    end else begin
      $display("** coo_sparse_matvec_core: FAILED **");
    end
    $finish;
  end

endmodule
